FILE: design/ims_pkg.sv
// Shared types, constants and helper functions for the Ising spin update block.
package ims_pkg;

  localparam int SIDE     = 64;
  localparam int IDX_W    = $clog2(SIDE);
  localparam int COORD_W  = 6;
  localparam int RAND_W   = 32;
  localparam int LEVEL_W  = 33;
  localparam int E_W      = 4;
  localparam int ENERGY_W = 15;
  localparam int MAG_W    = 14;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 64;

  localparam logic [ENERGY_W-1:0] ENERGY_RESET = ENERGY_W'(-2 * SIDE * SIDE);
  localparam logic [MAG_W-1:0]    MAG_RESET    = MAG_W'(SIDE * SIDE);
  localparam logic [LEVEL_W-1:0]  LEVEL_RESET  = {1'b1, {(LEVEL_W-1){1'b0}}};
  localparam logic [MAG_W-1:0]    MAG_STEP     = MAG_W'(2);

  // paddr[3] selects the register
  localparam logic REG_LEVEL_4 = 1'b0;
  localparam logic REG_LEVEL_2 = 1'b1;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UP,
    ST_DOWN,
    ST_MID
  } state_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] lvl4;
    logic [LEVEL_W-1:0] lvl2;
  } levels_t;

  typedef struct packed {
    logic self_spin;
    logic up;
    logic down;
    logic left;
    logic right;
  } site_t;

  typedef struct packed {
    logic                  change;
    logic signed [E_W-1:0] energy;
  } decision_t;

  // Coordinate modulo SIDE as a small constant table.
  function automatic logic [IDX_W-1:0] coord_reduce(input logic [COORD_W-1:0] c);
    logic [IDX_W-1:0] res;
    res = '0;
    for (int k = 0; k < (1 << COORD_W); k++) begin
      if (c == COORD_W'(k)) res = IDX_W'(k % SIDE);
    end
    return res;
  endfunction

  function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(SIDE - 1) : i - IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(SIDE - 1)) ? '0 : i + IDX_W'(1);
  endfunction

endpackage

FILE: design/ims_lattice_ram.sv
// Spin lattice memory: one row of spins per word, one port, registered read.
module ims_lattice_ram (
  input  logic                         clk,
  input  logic                         we,
  input  logic [ims_pkg::IDX_W-1:0]    addr,
  input  logic [ims_pkg::SIDE-1:0]     wdata,
  output logic [ims_pkg::SIDE-1:0]     rdata
);

  logic [ims_pkg::SIDE-1:0] lattice_mem [ims_pkg::SIDE];
  logic [ims_pkg::SIDE-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      lattice_mem[addr] <= wdata;
    end
    rdata_r <= lattice_mem[addr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/ims_cfg.sv
// APB register file holding the two acceptance levels.
module ims_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ims_pkg::ADDR_W-1:0]    paddr,
  input  logic [ims_pkg::DATA_W-1:0]    pwdata,
  output logic [ims_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output ims_pkg::levels_t              levels
);

  logic [ims_pkg::LEVEL_W-1:0] lvl4_r;
  logic [ims_pkg::LEVEL_W-1:0] lvl2_r;
  logic                        wr_en;
  logic                        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl4_r <= ims_pkg::LEVEL_RESET;
      lvl2_r <= ims_pkg::LEVEL_RESET;
    end else if (wr_en) begin
      if (reg_sel == ims_pkg::REG_LEVEL_4) begin
        lvl4_r <= pwdata[ims_pkg::LEVEL_W-1:0];
      end else begin
        lvl2_r <= pwdata[ims_pkg::LEVEL_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == ims_pkg::REG_LEVEL_4) begin
      prdata[ims_pkg::LEVEL_W-1:0] = lvl4_r;
    end else begin
      prdata[ims_pkg::LEVEL_W-1:0] = lvl2_r;
    end
  end

  assign levels.lvl4 = lvl4_r;
  assign levels.lvl2 = lvl2_r;

endmodule

FILE: design/ims_decide.sv
// Local energy and Metropolis accept decision for one site.
module ims_decide (
  input  ims_pkg::site_t                site,
  input  logic                          cmd,
  input  logic                          spin_value,
  input  logic [ims_pkg::RAND_W-1:0]    rand_u,
  input  ims_pkg::levels_t              levels,
  output ims_pkg::decision_t            dec
);

  logic [2:0]                   up_count;
  logic [ims_pkg::E_W-1:0]      twice;
  logic signed [ims_pkg::E_W-1:0] e;
  logic [ims_pkg::LEVEL_W-1:0]  u_ext;

  always_comb begin
    up_count = 3'(site.up) + 3'(site.down) + 3'(site.left) + 3'(site.right);
    twice    = {up_count, 1'b0};
    // +1 spin: e = 4 - 2k, -1 spin: e = 2k - 4
    if (site.self_spin) begin
      e = signed'(ims_pkg::E_W'(4) - twice);
    end else begin
      e = signed'(twice - ims_pkg::E_W'(4));
    end
    u_ext = {1'b0, rand_u};

    dec.energy = e;
    if (cmd == ims_pkg::CMD_WRITE) begin
      dec.change = (spin_value != site.self_spin);
    end else if (e > 1 || e == 0) begin
      dec.change = 1'b1;
    end else if (e == -2) begin
      dec.change = (u_ext < levels.lvl2);
    end else begin
      dec.change = (u_ext < levels.lvl4);
    end
  end

endmodule

FILE: design/ising_metropolis_spin_update.sv
// Top level of the 2D Ising Metropolis spin update block.
// A taken start steps through ST_UP, ST_DOWN and ST_MID; the result strobe is
// registered out of ST_MID. No new item is taken until the three single-port row
// reads (row above, row below, own row) and the own-row write-back are done.
// Reset (synchronous, active low) runs a clearing pass writing +1 rows; busy
// stays high meanwhile. Results are strobed for one cycle; no back-pressure.
module ising_metropolis_spin_update (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_cmd,
  input  logic [ims_pkg::COORD_W-1:0]        in_row,
  input  logic [ims_pkg::COORD_W-1:0]        in_col,
  input  logic [ims_pkg::RAND_W-1:0]         in_rand_u,
  input  logic                               in_spin_value,
  output logic                               out_valid,
  output logic                               out_flipped,
  output logic signed [ims_pkg::E_W-1:0]      out_local_energy,
  output logic signed [ims_pkg::ENERGY_W-1:0] out_total_energy,
  output logic signed [ims_pkg::MAG_W-1:0]    out_magnetization,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ims_pkg::ADDR_W-1:0]         paddr,
  input  logic [ims_pkg::DATA_W-1:0]         pwdata,
  output logic [ims_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  ims_pkg::state_t    state_r, state_nxt;
  ims_pkg::levels_t   levels;
  ims_pkg::site_t     site;
  ims_pkg::decision_t dec;

  logic [ims_pkg::IDX_W-1:0]    clr_row_r;
  logic [ims_pkg::IDX_W-1:0]    row_r;
  logic [ims_pkg::IDX_W-1:0]    col_r;
  logic                         cmd_r;
  logic                         spin_value_r;
  logic [ims_pkg::RAND_W-1:0]   rand_u_r;
  logic                         up_bit_r;
  logic                         down_bit_r;
  logic [ims_pkg::ENERGY_W-1:0] energy_sum_r;
  logic [ims_pkg::MAG_W-1:0]    spin_sum_r;
  logic                         out_valid_r;
  logic                         out_flipped_r;
  logic [ims_pkg::E_W-1:0]      out_energy_r;

  logic                         ram_we;
  logic [ims_pkg::IDX_W-1:0]    ram_addr;
  logic [ims_pkg::SIDE-1:0]     ram_wdata;
  logic [ims_pkg::SIDE-1:0]     ram_rdata;
  logic                         accept;
  logic [ims_pkg::IDX_W-1:0]    in_row_red;
  logic [ims_pkg::IDX_W-1:0]    in_col_red;
  logic [ims_pkg::ENERGY_W-1:0] energy_delta;
  logic [ims_pkg::MAG_W-1:0]    spin_delta;

  ims_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .levels  (levels)
  );

  ims_lattice_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  ims_decide u_decide (
    .site       (site),
    .cmd        (cmd_r),
    .spin_value (spin_value_r),
    .rand_u     (rand_u_r),
    .levels     (levels),
    .dec        (dec)
  );

  assign busy       = (state_r != ims_pkg::ST_IDLE);
  assign accept     = start && !busy;
  assign in_row_red = ims_pkg::coord_reduce(in_row);
  assign in_col_red = ims_pkg::coord_reduce(in_col);

  // own row is on the read port during ST_MID
  assign site.self_spin = ram_rdata[col_r];
  assign site.left      = ram_rdata[ims_pkg::wrap_dec(col_r)];
  assign site.right     = ram_rdata[ims_pkg::wrap_inc(col_r)];
  assign site.up        = up_bit_r;
  assign site.down      = down_bit_r;

  // bond energy changes by -2e, magnetization by twice the new spin
  assign energy_delta = -{{(ims_pkg::ENERGY_W-ims_pkg::E_W-1){dec.energy[ims_pkg::E_W-1]}},
                          dec.energy, 1'b0};
  assign spin_delta   = site.self_spin ? -ims_pkg::MAG_STEP : ims_pkg::MAG_STEP;

  always_comb begin
    state_nxt = state_r;
    ram_we    = 1'b0;
    ram_addr  = row_r;
    ram_wdata = ram_rdata;
    case (state_r)
      ims_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_row_r;
        ram_wdata = '1;
        if (clr_row_r == ims_pkg::IDX_W'(ims_pkg::SIDE - 1)) state_nxt = ims_pkg::ST_IDLE;
      end
      ims_pkg::ST_IDLE: begin
        ram_addr = ims_pkg::wrap_dec(in_row_red);
        if (start) state_nxt = ims_pkg::ST_UP;
      end
      ims_pkg::ST_UP: begin
        ram_addr  = ims_pkg::wrap_inc(row_r);
        state_nxt = ims_pkg::ST_DOWN;
      end
      ims_pkg::ST_DOWN: begin
        state_nxt = ims_pkg::ST_MID;
      end
      ims_pkg::ST_MID: begin
        // write back own row with the site toggled when dec.change is set
        ram_we            = dec.change;
        ram_wdata[col_r]  = ~ram_rdata[col_r];
        state_nxt         = ims_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = ims_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ims_pkg::ST_CLEAR;
      clr_row_r    <= '0;
      out_valid_r  <= 1'b0;
      energy_sum_r <= ims_pkg::ENERGY_RESET;
      spin_sum_r   <= ims_pkg::MAG_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ims_pkg::ST_MID);
      if (state_r == ims_pkg::ST_CLEAR) begin
        clr_row_r <= clr_row_r + ims_pkg::IDX_W'(1);
      end
      if (state_r == ims_pkg::ST_MID && dec.change) begin
        energy_sum_r <= energy_sum_r + energy_delta;
        spin_sum_r   <= spin_sum_r + spin_delta;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row_r        <= in_row_red;
      col_r        <= in_col_red;
      cmd_r        <= in_cmd;
      spin_value_r <= in_spin_value;
      rand_u_r     <= in_rand_u;
    end
    if (state_r == ims_pkg::ST_UP) begin
      up_bit_r <= ram_rdata[col_r];
    end
    if (state_r == ims_pkg::ST_DOWN) begin
      down_bit_r <= ram_rdata[col_r];
    end
    if (state_r == ims_pkg::ST_MID) begin
      out_flipped_r <= dec.change;
      out_energy_r  <= dec.energy;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_flipped       = out_flipped_r;
  assign out_local_energy  = signed'(out_energy_r);
  assign out_total_energy  = signed'(energy_sum_r);
  assign out_magnetization = signed'(spin_sum_r);

endmodule

FILE: design/ims_checker.sv
// Port-level checks for the Ising spin update block, bound to the top level.
module ims_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               out_valid,
  input logic                               out_flipped,
  input logic signed [ims_pkg::E_W-1:0]      out_local_energy,
  input logic signed [ims_pkg::ENERGY_W-1:0] out_total_energy,
  input logic signed [ims_pkg::MAG_W-1:0]    out_magnetization
);

  // a taken word is followed by its result strobe
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##4 out_valid)
    else $error("result strobe missing four cycles after start");

  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy high during result cycle");

  a_hold_sums: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_flipped |-> $stable(out_total_energy) && $stable(out_magnetization))
    else $error("running sums moved without a flip");

  a_flip_moves_mag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_flipped |-> out_magnetization != $past(out_magnetization))
    else $error("flip left magnetization unchanged");

  a_even_energy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_local_energy[0] == 1'b0)
    else $error("odd local energy");

endmodule

bind ising_metropolis_spin_update ims_checker u_ims_checker (.*);
